>>> sv/vlc_pkg.sv
package vlc_pkg;

   localparam int LEVEL_W     = 10;
   localparam int PERIOD_W    = 10;
   localparam int THRESHOLD_W = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 8;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_PERIOD    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT_THRESHOLD = 1'd1;

   localparam logic [PERIOD_W-1:0]    BLINK_PERIOD_RESET    = 10'd300;
   localparam logic [THRESHOLD_W-1:0] LIGHT_THRESHOLD_RESET = 8'd113;

   // open ranges of the button ladder
   localparam logic [LEVEL_W-1:0] RIGHT_LO  = 10'd757;
   localparam logic [LEVEL_W-1:0] RIGHT_HI  = 10'd777;
   localparam logic [LEVEL_W-1:0] LIGHT_LO  = 10'd502;
   localparam logic [LEVEL_W-1:0] LIGHT_HI  = 10'd522;
   localparam logic [LEVEL_W-1:0] BRAKE1_LO = 10'd842;
   localparam logic [LEVEL_W-1:0] BRAKE1_HI = 10'd862;
   localparam logic [LEVEL_W-1:0] BRAKE2_LO = 10'd808;
   localparam logic [LEVEL_W-1:0] BRAKE2_HI = 10'd828;
   localparam logic [LEVEL_W-1:0] LEFT_LO   = 10'd867;
   localparam logic [LEVEL_W-1:0] LEFT_HI   = 10'd887;
   localparam logic [LEVEL_W-1:0] HAZARD_LO = 10'd672;
   localparam logic [LEVEL_W-1:0] HAZARD_HI = 10'd692;

   typedef enum logic [2:0] {
      BTN_NONE   = 3'd0,
      BTN_RIGHT  = 3'd1,
      BTN_LIGHT  = 3'd2,
      BTN_BRAKE1 = 3'd3,
      BTN_BRAKE2 = 3'd4,
      BTN_LEFT   = 3'd5,
      BTN_HAZARD = 3'd6
   } btn_type;

   typedef struct packed {
      btn_type               prev_button;
      logic                  left_req;
      logic                  right_req;
      logic                  hazard_req;
      logic                  brake;
      logic                  position;
      logic                  auto_mode;
      logic                  phase;
      logic [PERIOD_W-1:0]   tick_count;
      logic                  left_out;
      logic                  right_out;
   } state_type;

   // no button, no requests, lamps off, automatic mode on, count and phase clear
   localparam state_type STATE_RESET = {BTN_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                        1'b1, 1'b0, 10'd0, 1'b0, 1'b0};

   typedef struct packed {
      logic [LEVEL_W-1:0] button_level;
      logic [LEVEL_W-1:0] light_level;
      logic               tick;
   } req_type;

   // highest field first, so the packed vector matches rsp_tdata
   typedef struct packed {
      btn_type button_code;
      logic    automatic_mode;
      logic    position_lamp;
      logic    brake_lamp;
      logic    right_lamp;
      logic    left_lamp;
   } rsp_type;

   function automatic logic in_range(input logic [LEVEL_W-1:0] level,
                                     input logic [LEVEL_W-1:0] lo,
                                     input logic [LEVEL_W-1:0] hi);
      in_range = (level > lo) && (level < hi);
   endfunction

   // first matching range wins
   function automatic btn_type decode_button(input logic [LEVEL_W-1:0] level);
      if (in_range(level, RIGHT_LO, RIGHT_HI)) begin
         decode_button = BTN_RIGHT;
      end else if (in_range(level, LIGHT_LO, LIGHT_HI)) begin
         decode_button = BTN_LIGHT;
      end else if (in_range(level, BRAKE1_LO, BRAKE1_HI)) begin
         decode_button = BTN_BRAKE1;
      end else if (in_range(level, BRAKE2_LO, BRAKE2_HI)) begin
         decode_button = BTN_BRAKE2;
      end else if (in_range(level, LEFT_LO, LEFT_HI)) begin
         decode_button = BTN_LEFT;
      end else if (in_range(level, HAZARD_LO, HAZARD_HI)) begin
         decode_button = BTN_HAZARD;
      end else begin
         decode_button = BTN_NONE;
      end
   endfunction

endpackage

>>> sv/vlc_step.sv
module vlc_step (
   input  vlc_pkg::state_type                  st,
   input  vlc_pkg::req_type                    req,
   input  logic [vlc_pkg::PERIOD_W-1:0]        blink_period,
   input  logic [vlc_pkg::THRESHOLD_W-1:0]     light_threshold,
   output vlc_pkg::state_type                  st_next,
   output vlc_pkg::rsp_type                    rsp
);

   vlc_pkg::btn_type                code;
   logic                            press;
   logic                            is_brake;
   logic [17:0]                     light_x255;
   logic [8:0]                      thr_p1;
   logic [18:0]                     thr_x1023;
   logic [vlc_pkg::PERIOD_W-1:0]    cnt_inc;
   vlc_pkg::state_type              s;

   assign code       = vlc_pkg::decode_button(req.button_level);
   assign press      = (code != vlc_pkg::BTN_NONE) && (code != st.prev_button);
   assign is_brake   = (code == vlc_pkg::BTN_BRAKE1) || (code == vlc_pkg::BTN_BRAKE2);
   // floor(light*255/1023) > thr  <=>  light*255 >= (thr+1)*1023
   assign light_x255 = {req.light_level, 8'd0} - {8'd0, req.light_level};
   assign thr_p1     = {1'b0, light_threshold} + 9'd1;
   assign thr_x1023  = {thr_p1, 10'd0} - {10'd0, thr_p1};
   assign cnt_inc    = st.tick_count + 10'd1;

   always_comb begin
      s = st;
      if (press) begin
         case (code)
            vlc_pkg::BTN_RIGHT: begin
               s.right_req = !st.right_req;
               s.left_req  = 1'b0;
            end
            vlc_pkg::BTN_LIGHT: begin
               s.position  = !st.position;
               s.auto_mode = 1'b0;
            end
            vlc_pkg::BTN_BRAKE1, vlc_pkg::BTN_BRAKE2: begin
               s.brake = 1'b1;
            end
            vlc_pkg::BTN_LEFT: begin
               s.left_req  = !st.left_req;
               s.right_req = 1'b0;
            end
            vlc_pkg::BTN_HAZARD: begin
               s.hazard_req = !st.hazard_req;
            end
            default: begin
               s.hazard_req = st.hazard_req;
            end
         endcase
      end
      s.prev_button = code;

      if (s.auto_mode) begin
         s.position = ({1'b0, light_x255} >= thr_x1023);
      end

      if (!is_brake) begin
         s.brake = 1'b0;
      end

      if (req.tick) begin
         if (cnt_inc >= blink_period) begin
            s.tick_count = '0;
            s.phase      = !st.phase;
         end else begin
            s.tick_count = cnt_inc;
         end
      end

      if (s.hazard_req) begin
         s.left_out  = s.phase;
         s.right_out = s.phase;
      end else if (s.left_req) begin
         if (s.phase) begin
            s.left_out  = 1'b1;
            s.right_out = 1'b0;
         end else begin
            s.left_out = 1'b0;
         end
      end else if (s.right_req) begin
         if (s.phase) begin
            s.right_out = 1'b1;
            s.left_out  = 1'b0;
         end else begin
            s.right_out = 1'b0;
         end
      end else begin
         s.left_out  = 1'b0;
         s.right_out = 1'b0;
      end
   end

   assign st_next            = s;
   assign rsp.left_lamp      = s.left_out;
   assign rsp.right_lamp     = s.right_out;
   assign rsp.brake_lamp     = s.brake;
   assign rsp.position_lamp  = s.position;
   assign rsp.automatic_mode = s.auto_mode;
   assign rsp.button_code    = code;

endmodule

>>> sv/vehicle_light_controller.sv
// Path: an accepted req item goes through the input register, then the result
//   register, before it leaves as its rsp item.
// Throughput: one item per cycle while rsp_tready is high; the lamp state updates
//   in the single step between the two registers, so the next item already sees it.
// Reset (synchronous, active high): both registers empty, lamps off, automatic
//   mode on, blink period 300 ticks, light threshold 113.
module vehicle_light_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [9:0] button_level, [19:10] light_level, [20] tick, [23:21] zero
   input  logic [vlc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] left_lamp, [1] right_lamp, [2] brake_lamp, [3] position_lamp,
   // [4] automatic_mode, [7:5] button_code
   output logic [vlc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [vlc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vlc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // configuration registers
   logic [vlc_pkg::PERIOD_W-1:0]    period_ff, period_in;
   logic [vlc_pkg::THRESHOLD_W-1:0] thr_ff, thr_in;

   // input register
   logic                req_valid_ff, req_valid_in;
   vlc_pkg::req_type    req_ff, req_in;

   // lamp state, updated as an item moves to the result register
   vlc_pkg::state_type  st_ff, st_in, st_next;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   vlc_pkg::rsp_type    rsp_ff, rsp_in, rsp_next;

   logic                advance;

   // Move the held item forward when the result register is free or drains now.
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   // Write configuration; the threshold takes the low byte.
   always_comb begin
      period_in = period_ff;
      thr_in    = thr_ff;
      if (csr_we) begin
         case (csr_index)
            vlc_pkg::CSR_BLINK_PERIOD:    period_in = csr_wdata;
            vlc_pkg::CSR_LIGHT_THRESHOLD: thr_in    = csr_wdata[vlc_pkg::THRESHOLD_W-1:0];
            default:                      period_in = period_ff;
         endcase
      end
   end

   // Capture a new item whenever the input register frees up.
   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      if (req_tready) begin
         req_valid_in          = req_tvalid;
         req_in.button_level   = req_tdata[9:0];
         req_in.light_level    = req_tdata[19:10];
         req_in.tick           = req_tdata[20];
      end
   end

   vlc_step u_step (
      .st              (st_ff),
      .req             (req_ff),
      .blink_period    (period_ff),
      .light_threshold (thr_ff),
      .st_next         (st_next),
      .rsp             (rsp_next)
   );

   // Commit state and load the result together; otherwise hold, clearing valid once taken.
   always_comb begin
      st_in        = st_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance) begin
         st_in        = st_next;
         rsp_in       = rsp_next;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff              <= vlc_pkg::BLINK_PERIOD_RESET;
         thr_ff                 <= vlc_pkg::LIGHT_THRESHOLD_RESET;
         req_valid_ff           <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         st_ff                  <= vlc_pkg::STATE_RESET;
      end else begin
         period_ff    <= period_in;
         thr_ff       <= thr_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // Turn requests are exclusive.
   a_turn_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(st_ff.left_req && st_ff.right_req))
      else $error("left and right requests both set");

   // Leaving automatic mode is permanent until reset.
   a_auto_sticky: assert property (@(posedge clock) disable iff (reset)
      !st_ff.auto_mode |=> !st_ff.auto_mode)
      else $error("automatic mode came back");

   // Hazard drives both indicators alike.
   a_hazard_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && st_ff.hazard_req) |-> (rsp_ff.left_lamp == rsp_ff.right_lamp))
      else $error("hazard with unequal indicators");

   // Brake lamp only while a brake button is decoded.
   a_brake_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.brake_lamp) |->
         (rsp_ff.button_code == vlc_pkg::BTN_BRAKE1 ||
          rsp_ff.button_code == vlc_pkg::BTN_BRAKE2))
      else $error("brake lamp without brake button");

   // A held item is never lost while the output stalls.
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> (req_valid_ff && $stable(req_ff)))
      else $error("stalled item dropped");

endmodule
